### src/assert_macros.svh
// Assertion macros used by the checker file dqp_checker.sv.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DQP_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DQP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/dqp_pkg.sv
// Shared types and constants for the dotted-quad IPv4 parser.
// No dependencies.
`timescale 1ns / 1ps

package dqp_pkg;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_NUL  = 8'h00;

    localparam logic [11:0] OCTET_MAX  = 12'd255;
    localparam logic [1:0]  LAST_OCTET = 2'd3;
    localparam logic [1:0]  MAX_DIGITS = 2'd3;

    typedef enum logic {
        PS_IDLE,
        PS_ACTIVE
    } parse_state_t;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_DIGIT,
        EV_SEP,
        EV_DONE,
        EV_FAIL
    } parse_event_t;

    typedef struct packed {
        logic [7:0] char_in;
        logic       start_flag;
    } in_word_t;

    typedef struct packed {
        logic [31:0] address;
        logic        fail;
    } result_t;

endpackage

### src/dqp_in_reg.sv
// Input register stage of the parser.
// Depends on dqp_pkg.
`timescale 1ns / 1ps

module dqp_in_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [7:0]       char_in,
    input  logic             start_flag,
    input  logic             advance,
    output logic             in_stall,
    output logic             full,
    output dqp_pkg::in_word_t word
);

    logic              full_reg;
    logic              full_next;
    dqp_pkg::in_word_t word_reg;
    logic              accept;

    // hold only while the downstream side cannot take the held word
    assign in_stall = full_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
        else
        begin
            full_next = full_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg.char_in    <= char_in;
            word_reg.start_flag <= start_flag;
        end
    end

    assign full = full_reg;
    assign word = word_reg;

endmodule

### src/dqp_parse_core.sv
// Parse state and per-character step logic.
// Depends on dqp_pkg.
`timescale 1ns / 1ps

module dqp_parse_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  dqp_pkg::in_word_t word,
    output logic              res_valid,
    output dqp_pkg::result_t  result
);

    dqp_pkg::parse_state_t state_reg;
    dqp_pkg::parse_state_t state_next;
    logic [1:0]            index_reg;
    logic [1:0]            index_next;
    logic [1:0]            count_reg;
    logic [1:0]            count_next;
    logic [7:0]            value_reg;
    logic [7:0]            value_next;
    logic [23:0]           acc_reg;
    logic [23:0]           acc_next;

    // values seen by this character; a start flag wipes the string
    logic                  eff_active;
    logic [1:0]            eff_index;
    logic [1:0]            eff_count;
    logic [7:0]            eff_value;
    logic [23:0]           eff_acc;
    logic                  char_num;
    logic                  is_term;
    logic [11:0]           prod;
    dqp_pkg::parse_event_t ev;

    always_comb
    begin
        if (word.start_flag)
        begin
            eff_active = 1'b1;
            eff_index  = '0;
            eff_count  = '0;
            eff_value  = '0;
            eff_acc    = '0;
        end
        else
        begin
            eff_active = (state_reg == dqp_pkg::PS_ACTIVE);
            eff_index  = index_reg;
            eff_count  = count_reg;
            eff_value  = value_reg;
            eff_acc    = acc_reg;
        end
    end

    assign char_num = (word.char_in >= dqp_pkg::CH_ZERO)
                   && (word.char_in <= dqp_pkg::CH_NINE);
    assign is_term  = (word.char_in == dqp_pkg::CH_DOT) || (word.char_in == dqp_pkg::CH_NUL);
    // value * 10 + digit
    assign prod = {1'b0, eff_value, 3'b000} + {3'b000, eff_value, 1'b0}
                + {8'h00, word.char_in[3:0]};

    // classify the character against the current string
    always_comb
    begin
        if (!eff_active)
        begin
            ev = dqp_pkg::EV_NONE;
        end
        else if (char_num)
        begin
            if (eff_count >= dqp_pkg::MAX_DIGITS || prod > dqp_pkg::OCTET_MAX)
            begin
                ev = dqp_pkg::EV_FAIL;
            end
            else
            begin
                ev = dqp_pkg::EV_DIGIT;
            end
        end
        else if (is_term)
        begin
            if (eff_count == 2'd0)
            begin
                ev = dqp_pkg::EV_FAIL;
            end
            else if (eff_index == dqp_pkg::LAST_OCTET)
            begin
                ev = dqp_pkg::EV_DONE;   // dot or NUL both close the last octet
            end
            else if (word.char_in == dqp_pkg::CH_NUL)
            begin
                ev = dqp_pkg::EV_FAIL;
            end
            else
            begin
                ev = dqp_pkg::EV_SEP;
            end
        end
        else
        begin
            ev = dqp_pkg::EV_FAIL;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            unique case (ev)
                dqp_pkg::EV_DIGIT, dqp_pkg::EV_SEP: state_next = dqp_pkg::PS_ACTIVE;
                dqp_pkg::EV_DONE, dqp_pkg::EV_FAIL: state_next = dqp_pkg::PS_IDLE;
                default:                            state_next = state_reg;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        index_next = index_reg;
        count_next = count_reg;
        value_next = value_reg;
        acc_next   = acc_reg;
        res_valid  = 1'b0;
        result.address = '0;
        result.fail    = 1'b0;
        if (step)
        begin
            unique case (ev)
                dqp_pkg::EV_DIGIT:
                begin
                    index_next = eff_index;
                    count_next = eff_count + 2'd1;
                    value_next = prod[7:0];
                    acc_next   = eff_acc;
                end
                dqp_pkg::EV_SEP:
                begin
                    index_next = eff_index + 2'd1;
                    count_next = '0;
                    value_next = '0;
                    acc_next   = {eff_acc[15:0], eff_value};
                end
                dqp_pkg::EV_DONE:
                begin
                    index_next = '0;
                    count_next = '0;
                    value_next = '0;
                    acc_next   = '0;
                    res_valid  = 1'b1;
                    result.address = {eff_acc, eff_value};
                end
                dqp_pkg::EV_FAIL:
                begin
                    index_next = '0;
                    count_next = '0;
                    value_next = '0;
                    acc_next   = '0;
                    res_valid  = 1'b1;
                    result.fail = 1'b1;
                end
                default:
                begin
                    index_next = index_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dqp_pkg::PS_IDLE;
            index_reg <= '0;
            count_reg <= '0;
            value_reg <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            index_reg <= index_next;
            count_reg <= count_next;
            value_reg <= value_next;
            acc_reg   <= acc_next;
        end
    end

endmodule

### src/dqp_out_reg.sv
// Result register stage of the parser.
// Depends on dqp_pkg.
`timescale 1ns / 1ps

module dqp_out_reg
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             res_valid,
    input  dqp_pkg::result_t result,
    input  logic             out_stall,
    output logic             advance,
    output logic             out_valid,
    output logic [31:0]      address,
    output logic             fail
);

    logic             valid_reg;
    logic             valid_next;
    dqp_pkg::result_t data_reg;

    // register is free when empty or being taken this cycle
    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? res_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign address   = data_reg.address;
    assign fail      = data_reg.fail;

endmodule

### src/dotted_quad_ipv4_parser.sv
// An accepted character is held in the input register and is parsed as it leaves
// it; that step loads its result, if any, into the result register.
// Throughput: one character per cycle; input stalls only behind a stalled result.
// Reset: rst_n asynchronous, active low; clears the parse state to idle and empties
// both register stages.
// Depends on dqp_pkg, dqp_in_reg, dqp_parse_core, dqp_out_reg.
`timescale 1ns / 1ps

module dotted_quad_ipv4_parser
(
    input  logic        clk,
    input  logic        rst_n,
    // character input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_in,
    input  logic        start_flag,
    // result channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] address,
    output logic        fail
);

    // advance: the result register can take whatever this cycle's step gives,
    // so the held character may be parsed now
    logic              advance;
    logic              in_full;
    dqp_pkg::in_word_t in_word;
    logic              res_valid;
    dqp_pkg::result_t  result;

    // input register: parts the source from the parse logic
    dqp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .char_in    (char_in),
        .start_flag (start_flag),
        .advance    (advance),
        .in_stall   (in_stall),
        .full       (in_full),
        .word       (in_word)
    );

    // one step of the parse per held word; most words give no result
    dqp_parse_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_full && advance),
        .word      (in_word),
        .res_valid (res_valid),
        .result    (result)
    );

    // result register: holds a finished word while the sink stalls
    dqp_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .result    (result),
        .out_stall (out_stall),
        .advance   (advance),
        .out_valid (out_valid),
        .address   (address),
        .fail      (fail)
    );

endmodule

### src/dqp_checker.sv
// Port-level checks for the dotted-quad IPv4 parser, bound to the top level.
// Depends on assert_macros.svh and dotted_quad_ipv4_parser.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dqp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] address,
    input logic        fail
);

    logic        in_acc;
    logic        out_held;
    logic [32:0] out_word;

    assign in_acc   = in_valid && !in_stall;
    assign out_held = out_valid && out_stall;
    assign out_word = {address, fail};

    // a failed parse carries a zero address
    `DQP_ASSERT_IMPLY(a_fail_zero, clk, rst_n, out_valid && fail, address == '0, "fail, addr set")

    // input only backs up behind a stalled result
    `DQP_ASSERT_IMPLY(a_stall_cause, clk, rst_n, in_stall, out_held, "stray input stall")

    // a new result follows an accepted input word, through both register stages
    `DQP_ASSERT_IMPLY(a_res_source, clk, rst_n, $rose(out_valid), $past(in_acc, 2), "stray result")

    // a stalled result holds
    `DQP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_held, out_valid && $stable(out_word), "word moved")

endmodule

bind dotted_quad_ipv4_parser dqp_checker u_dqp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .address    (address),
    .fail       (fail)
);

### bench/tb_dotted_quad_ipv4_parser.sv
// Testbench for dotted_quad_ipv4_parser: a directed character table, then random
// address strings, each result checked against the row's own expectation or an in-bench parse predictor.
// Depends on dqp_pkg and the dotted_quad_ipv4_parser RTL.
`timescale 1ns / 1ps

module tb_dotted_quad_ipv4_parser;

    import dqp_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and the block's ports
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [7:0]  char_in    = 8'h00;
    logic        start_flag = 1'b0;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] address;
    logic        fail;

    // The receiver's stall is its own per-result wait, or the long hold-off.
    logic        rx_stall   = 1'b0;
    logic        hold_off   = 1'b0;
    assign out_stall = rx_stall | hold_off;

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    dotted_quad_ipv4_parser i_dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_in    (char_in),
        .start_flag (start_flag),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .address    (address),
        .fail       (fail)
    );

    // ------------------------------------------------------------------
    // Words sent to the block. A row may carry its own expectation (typed);
    // otherwise the parse predictor supplies it.
    // ------------------------------------------------------------------
    typedef struct {
        logic [7:0] ch;
        logic       sof;
        bit         typed;
        bit         gives;
        result_t    res;
    } char_row_t;

    // Ways a random string gets broken.
    typedef enum int unsigned {
        FLAW_NONE,
        FLAW_BYTE,
        FLAW_EARLY_NUL,
        FLAW_EMPTY,
        FLAW_BIG,
        FLAW_LONG,
        FLAW_CUT
    } flaw_t;

    localparam result_t NO_RESULT  = '{32'd0, 1'b0};
    localparam result_t BAD_STRING = '{32'd0, 1'b1};

    // Directed part: ignored idle char, a good address with a trailing dot
    // (octets 0 and 255 inside), empty octet, octet over 255, early NUL,
    // fourth digit, restart in mid-string into a non-digit, idle 0xFF.
    char_row_t directed_rows [24] = '{
        '{"x",    1'b0, 1'b1, 1'b0, NO_RESULT},
        '{"9",    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{CH_DOT, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"2",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"5",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"5",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_DOT, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"0",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_DOT, 1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"1",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{CH_DOT, 1'b0, 1'b1, 1'b1, '{32'h09FF_0001, 1'b0}},
        '{CH_DOT, 1'b1, 1'b1, 1'b1, BAD_STRING},
        '{"2",    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{"5",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"6",    1'b0, 1'b1, 1'b1, BAD_STRING},
        '{"1",    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{CH_NUL, 1'b0, 1'b1, 1'b1, BAD_STRING},
        '{"0",    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{"0",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"0",    1'b0, 1'b0, 1'b0, NO_RESULT},
        '{"0",    1'b0, 1'b1, 1'b1, BAD_STRING},
        '{"1",    1'b1, 1'b0, 1'b0, NO_RESULT},
        '{"a",    1'b1, 1'b1, 1'b1, BAD_STRING},
        '{8'hFF,  1'b0, 1'b1, 1'b0, NO_RESULT}
    };

    int unsigned corner_octets [6] = '{0, 9, 10, 99, 100, 255};

    // ------------------------------------------------------------------
    // Parse predictor: its own copy of the parse state
    // ------------------------------------------------------------------
    parse_state_t parse_state = PS_IDLE;
    logic [1:0]   octet_pos   = 2'd0;
    logic [1:0]   digits_seen = 2'd0;
    logic [9:0]   octet_acc   = 10'd0;
    logic [31:0]  addr_acc    = 32'd0;

    result_t      pending_results [$];   // addresses / failures still owed by the block
    logic [7:0]   text_buf [$];          // random string being built
    int unsigned  live_words  = 0;       // accepted words the block did not ignore
    int unsigned  mismatches  = 0;
    bit           tx_burst    = 1'b0;
    bit           rx_burst    = 1'b0;
    result_t      want;

    function automatic void clear_string();
        octet_pos   = 2'd0;
        digits_seen = 2'd0;
        octet_acc   = 10'd0;
        addr_acc    = 32'd0;
    endfunction

    function automatic bit close_string(output result_t r, input logic [31:0] a,
                                        input logic f);
        r.address   = a;
        r.fail      = f;
        parse_state = PS_IDLE;
        clear_string();
        return 1'b1;
    endfunction

    // One character through the parser; returns 1 when it ends the string.
    function automatic bit parse_char(input logic [7:0] c, input logic sof,
                                      output result_t r);
        logic [11:0] grown;
        r = NO_RESULT;
        if (sof)
        begin
            parse_state = PS_ACTIVE;
            clear_string();
        end
        if (parse_state == PS_IDLE)
            return 1'b0;

        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (digits_seen >= MAX_DIGITS)
                return close_string(r, 32'd0, 1'b1);
            grown       = 12'(octet_acc * 10 + (c - CH_ZERO));
            octet_acc   = grown[9:0];
            digits_seen = digits_seen + 2'd1;
            if (grown > OCTET_MAX)
                return close_string(r, 32'd0, 1'b1);
            return 1'b0;
        end

        if (c == CH_DOT || c == CH_NUL)
        begin
            if (digits_seen == 2'd0)
                return close_string(r, 32'd0, 1'b1);
            addr_acc = {addr_acc[23:0], octet_acc[7:0]};
            if (octet_pos == LAST_OCTET)
                return close_string(r, addr_acc, 1'b0);
            if (c == CH_NUL)
                return close_string(r, 32'd0, 1'b1);
            octet_pos   = octet_pos + 2'd1;
            digits_seen = 2'd0;
            octet_acc   = 10'd0;
            return 1'b0;
        end

        return close_string(r, 32'd0, 1'b1);
    endfunction

    // Idle cycles before the next word or result; bursts toggle now and then.
    function automatic int unsigned draw_idle(inout bit burst);
        if ($urandom_range(0, 31) == 0)
            burst = !burst;
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    // Decimal digits of v, padded with leading zeros to at least nd digits.
    function automatic void put_number(input int unsigned v, input int unsigned nd);
        int unsigned need;
        int unsigned i;
        need = (v > 99) ? 3 : (v > 9) ? 2 : 1;
        if (nd < need)
            nd = need;
        for (i = nd; i > 0; i--)
            text_buf.push_back(8'(CH_ZERO + (v / (10 ** (i - 1))) % 10));
    endfunction

    // ------------------------------------------------------------------
    // Sender: one word, driven at the falling edge, held until accepted.
    // Prediction runs at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_word(input char_row_t w);
        int unsigned gap;
        result_t     guess;
        bit          ends;
        gap = hold_off ? 0 : draw_idle(tx_burst);   // keep pushing while held off
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        char_in    <= w.ch;
        start_flag <= w.sof;
        do
            @(posedge clk);
        while (in_stall);

        if (w.sof || parse_state == PS_ACTIVE)
            live_words++;
        ends = parse_char(w.ch, w.sof, guess);
        if (w.typed)
        begin
            if (w.gives)
                pending_results.push_back(w.res);
        end
        else if (ends)
            pending_results.push_back(guess);
        @(negedge clk);
    endtask

    // Mostly well-formed addresses with random octets; some broken on purpose,
    // some preceded by loose characters with no start.
    task automatic send_random_string();
        flaw_t       flaw;
        int unsigned bad;
        int unsigned k;
        int unsigned val;
        int unsigned keep;
        char_row_t   row;

        row.typed = 1'b0;
        row.gives = 1'b0;
        row.res   = NO_RESULT;

        if ($urandom_range(0, 11) == 0)
        begin
            row.sof = 1'b0;
            repeat ($urandom_range(1, 4))
            begin
                row.ch = 8'($urandom);
                send_word(row);
            end
        end

        flaw = FLAW_NONE;
        if ($urandom_range(0, 99) < 30)
            flaw = flaw_t'($urandom_range(FLAW_BYTE, FLAW_CUT));
        bad = $urandom_range(0, 3);

        text_buf.delete();
        for (k = 0; k < 4; k++)
        begin
            val = ($urandom_range(0, 3) == 0) ? corner_octets[$urandom_range(0, 5)]
                                                : $urandom_range(0, 255);
            if (flaw == FLAW_EMPTY && k == bad)
                ;                                      // octet with no digits
            else if (flaw == FLAW_BIG && k == bad)
                put_number($urandom_range(256, 999), 3);
            else if (flaw == FLAW_LONG && k == bad)
            begin
                put_number(val, 3);
                text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            else
                put_number(val, ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1);

            if (k < 3)
                text_buf.push_back((flaw == FLAW_EARLY_NUL && k == bad) ? CH_NUL : CH_DOT);
            else
                text_buf.push_back(($urandom_range(0, 3) == 0) ? CH_DOT : CH_NUL);
        end

        if (flaw == FLAW_BYTE)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom);
        if (flaw == FLAW_CUT)
        begin
            // left unfinished; the next start abandons it
            keep = $urandom_range(1, text_buf.size() - 1);
            while (text_buf.size() > keep)
                void'(text_buf.pop_back());
        end

        foreach (text_buf[pos])
        begin
            row.ch  = text_buf[pos];
            row.sof = (pos == 0);
            send_word(row);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random strings, drain, verdict
    // ------------------------------------------------------------------
    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i]);
        while (live_words < 1400)
            send_random_string();
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);     // anything stray after the last result

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random wait before each result, then take it
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned w;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            w = draw_idle(rx_burst);
            if (w != 0)
            begin
                rx_stall <= 1'b1;
                repeat (w) @(negedge clk);
            end
            rx_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
            @(negedge clk);
        end
    end

    // Long hold-offs while the sender keeps offering words: the block must
    // fill and push back on its input.
    initial
    begin
        int unsigned mark;
        for (mark = 300; mark <= 900; mark += 600)
        begin
            wait (live_words >= mark);
            @(negedge clk);
            hold_off <= 1'b1;
            repeat (150) @(negedge clk);
            hold_off <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result check, field by field, against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected word address=%h fail=%b",
                             $realtime, address, fail);
            end
            else
            begin
                want = pending_results.pop_front();
                if (address !== want.address || fail !== want.fail)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: mismatch address exp=%h got=%h fail exp=%b got=%b",
                                 $realtime, want.address, address, want.fail, fail);
                end
            end
        end
    end

    // Hard stop far beyond the slowest correct run.
    initial
    begin
        #5000000;
        $display("tb: failure");
        $finish;
    end

endmodule
